[sv/cmf_pkg.sv]
// ----------------------------------------------------------------------------
// cmf_pkg
// Shared sizes, operation and status codes for the closable message FIFO.
// ----------------------------------------------------------------------------
package cmf_pkg;

    localparam int unsigned SLOT_DEPTH = 16;
    localparam int unsigned DATA_W     = 64;
    localparam int unsigned ADDR_W     = $clog2(SLOT_DEPTH);
    localparam int unsigned LEVEL_W    = $clog2(SLOT_DEPTH + 1);
    localparam int unsigned COUNT_W    = 32;
    localparam int unsigned KIND_W     = 2;
    localparam int unsigned STATUS_W   = 2;

    typedef logic [KIND_W-1:0]   t_kind;
    typedef logic [STATUS_W-1:0] t_status;
    typedef logic [DATA_W-1:0]   t_word;
    typedef logic [ADDR_W-1:0]   t_addr;
    typedef logic [LEVEL_W-1:0]  t_level;
    typedef logic [COUNT_W-1:0]  t_count;

    localparam t_kind KIND_SEND  = 2'd0;
    localparam t_kind KIND_RECV  = 2'd1;
    localparam t_kind KIND_CLOSE = 2'd2;

    localparam t_status ST_DONE   = 2'd0;
    localparam t_status ST_BLOCK  = 2'd1;
    localparam t_status ST_CLOSED = 2'd2;

    localparam t_level LEVEL_DEPTH = t_level'(SLOT_DEPTH);

    // Step a pointer, wrapping to zero at the effective capacity.
    function automatic t_addr advance_ptr(input t_addr ptr, input t_level cap);
        t_level nxt;
        nxt = t_level'({1'b0, ptr}) + t_level'(1);
        if (nxt >= cap || nxt >= LEVEL_DEPTH) begin
            advance_ptr = '0;
        end else begin
            advance_ptr = nxt[ADDR_W-1:0];
        end
    endfunction

endpackage

[sv/closable_message_fifo.sv]
// ----------------------------------------------------------------------------
// closable_message_fifo
// Bounded message queue with a close flag and running counters.
// ----------------------------------------------------------------------------
//  channel  | direction | handshake                  | payload
//  ---------+-----------+----------------------------+---------------------------
//  in       | in        | i_in_valid / o_in_ready    | i_kind, i_data_in
//  out      | out       | o_out_valid / i_out_ready  | o_status, o_data_out, levels
//  cfg      | in        | i_cfg_we (no wait)         | i_cfg_data (slot limit)
//
//  One item per cycle unless a result stalls on i_out_ready; a result
//  appears in the cycle after its transfer in, and the slot RAM read port is registered too.
//  Reset is synchronous, active low; the slot contents are not cleared.
//  While a result waits on i_out_ready, o_in_ready stays low; it rises again
//  in the cycle in which the waiting result transfers.
// ----------------------------------------------------------------------------
module closable_message_fifo (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  logic                   i_cfg_we,
    input  logic [4:0]             i_cfg_data,
    input  logic                   i_in_valid,
    output logic                   o_in_ready,
    input  cmf_pkg::t_kind         i_kind,
    input  cmf_pkg::t_word         i_data_in,
    output logic                   o_out_valid,
    input  logic                   i_out_ready,
    output cmf_pkg::t_status       o_status,
    output cmf_pkg::t_word         o_data_out,
    output cmf_pkg::t_level        o_fill_level,
    output logic                   o_is_closed,
    output cmf_pkg::t_count        o_send_total,
    output cmf_pkg::t_count        o_recv_total,
    output cmf_pkg::t_count        o_refused_total
);
    import cmf_pkg::*;

    // Queue state
    t_addr   r_rd_ptr,  n_rd_ptr;
    t_addr   r_wr_ptr,  n_wr_ptr;
    t_level  r_occ,     n_occ;
    logic    r_closed,  n_closed;
    t_count  r_sends,   n_sends;
    t_count  r_recvs,   n_recvs;
    t_count  r_refused, n_refused;
    t_level  r_slot_limit;

    // Result register
    logic    r_out_valid;
    t_status r_status,  n_status;
    logic    r_rx_ok,   n_rx_ok;

    logic    w_accept;
    logic    w_we;
    logic    w_re;
    t_level  w_cap;
    t_word   w_rdata;

    assign o_in_ready = !r_out_valid || i_out_ready;
    assign w_accept   = i_in_valid && o_in_ready;

    // Effective capacity: zero acts as one slot, anything past the RAM
    // depth saturates to it.
    always_comb begin
        if (r_slot_limit == '0) begin
            w_cap = t_level'(1);
        end else if (r_slot_limit > LEVEL_DEPTH) begin
            w_cap = LEVEL_DEPTH;
        end else begin
            w_cap = r_slot_limit;
        end
    end

    // Decide the operation and the next queue state in the transfer cycle.
    always_comb begin
        n_rd_ptr  = r_rd_ptr;
        n_wr_ptr  = r_wr_ptr;
        n_occ     = r_occ;
        n_closed  = r_closed;
        n_sends   = r_sends;
        n_recvs   = r_recvs;
        n_refused = r_refused;
        n_status  = ST_DONE;
        n_rx_ok   = 1'b0;
        w_we      = 1'b0;
        w_re      = 1'b0;
        case (i_kind)
            KIND_SEND: begin
                if (r_closed) begin
                    n_status = ST_CLOSED;           // refused, not counted
                end else if (r_occ >= w_cap) begin
                    n_status  = ST_BLOCK;
                    n_refused = r_refused + t_count'(1);
                end else begin
                    w_we     = w_accept;
                    n_wr_ptr = advance_ptr(r_wr_ptr, w_cap);
                    n_occ    = r_occ + t_level'(1);
                    n_sends  = r_sends + t_count'(1);
                end
            end
            KIND_RECV: begin
                if (r_occ == '0) begin
                    if (r_closed) begin
                        n_status = ST_CLOSED;
                    end else begin
                        n_status  = ST_BLOCK;
                        n_refused = r_refused + t_count'(1);
                    end
                end else begin
                    // Head word keeps draining after close.
                    w_re     = w_accept;
                    n_rx_ok  = 1'b1;
                    n_rd_ptr = advance_ptr(r_rd_ptr, w_cap);
                    n_occ    = r_occ - t_level'(1);
                    n_recvs  = r_recvs + t_count'(1);
                end
            end
            KIND_CLOSE: begin
                n_closed = 1'b1;
            end
            default: begin
                // unused code: no operation, report levels as they stand
            end
        endcase
    end

    // Advance queue state and load the result on each transfer in.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_rd_ptr    <= '0;
            r_wr_ptr    <= '0;
            r_occ       <= '0;
            r_closed    <= 1'b0;
            r_sends     <= '0;
            r_recvs     <= '0;
            r_refused   <= '0;
            r_out_valid <= 1'b0;
            r_status    <= ST_DONE;
            r_rx_ok     <= 1'b0;
        end else begin
            if (w_accept) begin
                r_rd_ptr    <= n_rd_ptr;
                r_wr_ptr    <= n_wr_ptr;
                r_occ       <= n_occ;
                r_closed    <= n_closed;
                r_sends     <= n_sends;
                r_recvs     <= n_recvs;
                r_refused   <= n_refused;
                r_status    <= n_status;
                r_rx_ok     <= n_rx_ok;
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                // drop the result once it has transferred
                r_out_valid <= 1'b0;
            end
        end
    end

    // Slot limit register; the user must write it only while the queue is quiet (not enforced here).
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_slot_limit <= LEVEL_DEPTH;
        end else if (i_cfg_we) begin
            r_slot_limit <= i_cfg_data;
        end
    end

    // Slot storage. Read and write never target the same transfer, and a
    // word written in one cycle is visible to a read issued in the next.
    cmf_slot_ram #(
        .WIDTH (DATA_W),
        .DEPTH (SLOT_DEPTH),
        .AW    (ADDR_W)
    ) u_slot_ram (
        .i_clk   (i_clk),
        .i_we    (w_we),
        .i_waddr (r_wr_ptr),
        .i_wdata (i_data_in),
        .i_re    (w_re),
        .i_raddr (r_rd_ptr),
        .o_rdata (w_rdata)
    );

    // The queue state only moves on a transfer in, so while a result waits
    // the registers below still show the state after that item.
    assign o_out_valid     = r_out_valid;
    assign o_status        = r_status;
    assign o_data_out      = r_rx_ok ? w_rdata : '0;
    assign o_fill_level    = r_occ;
    assign o_is_closed     = r_closed;
    assign o_send_total    = r_sends;
    assign o_recv_total    = r_recvs;
    assign o_refused_total = r_refused;

endmodule

[sv/cmf_slot_ram.sv]
// ----------------------------------------------------------------------------
// cmf_slot_ram
// Simple dual-port RAM, one write and one registered read port.
// ----------------------------------------------------------------------------
module cmf_slot_ram #(
    parameter int unsigned WIDTH = 64,
    parameter int unsigned DEPTH = 16,
    parameter int unsigned AW    = $clog2(DEPTH)
) (
    input  logic             i_clk,
    input  logic             i_we,
    input  logic [AW-1:0]    i_waddr,
    input  logic [WIDTH-1:0] i_wdata,
    input  logic             i_re,
    input  logic [AW-1:0]    i_raddr,
    output logic [WIDTH-1:0] o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

[sv/cmf_checker.sv]
// ----------------------------------------------------------------------------
// cmf_port_assert
// Port-level checks for the closable message FIFO, bound to the top level.
// ----------------------------------------------------------------------------
module cmf_port_assert (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  logic                   o_out_valid,
    input  logic                   i_out_ready,
    input  cmf_pkg::t_status       o_status,
    input  cmf_pkg::t_word         o_data_out,
    input  cmf_pkg::t_level        o_fill_level,
    input  logic                   o_is_closed,
    input  cmf_pkg::t_count        o_send_total,
    input  cmf_pkg::t_count        o_recv_total,
    input  cmf_pkg::t_count        o_refused_total
);
    import cmf_pkg::*;

    // A stalled result holds.
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && !i_out_ready) |=>
            (o_out_valid && $stable(o_status) && $stable(o_data_out)))
        else $error("result changed while stalled");

    // A refused or closed operation returns no word.
    a_data_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_status != ST_DONE) |-> (o_data_out == '0))
        else $error("refused operation returned data");

    // Close is sticky across consecutive results.
    a_closed_sticky: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_is_closed) |=> (!o_out_valid || o_is_closed))
        else $error("closed flag cleared");

    // A result refused as closed moves no counter and no level.
    a_closed_no_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && i_out_ready) ##1 (o_out_valid && o_status == ST_CLOSED) |->
            (o_refused_total == $past(o_refused_total) &&
             o_send_total == $past(o_send_total) &&
             o_recv_total == $past(o_recv_total) &&
             o_fill_level == $past(o_fill_level)))
        else $error("closed refusal changed counters");

endmodule

bind closable_message_fifo cmf_port_assert u_cmf_port_assert (.*);
